/* src/nmea_pkg.sv */
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared types and constants of the NMEA RMC/GGA field parser.
// ----------------------------------------------------------------------------
package nmea_pkg;

  // Longest field held while it is open; longer fields are truncated.
  localparam int FIELD_LEN = 12;
  localparam int CC_W      = $clog2(FIELD_LEN + 1);
  localparam int IDX_W     = (FIELD_LEN > 1) ? $clog2(FIELD_LEN) : 1;

  localparam int TIME_LEN = 6;
  localparam int DATE_LEN = 6;
  localparam int SAT_LEN  = 2;
  localparam int NAME_LEN = 5;

  localparam logic [3:0] FIELD_MAX = 4'd15;
  localparam logic [3:0] FLD_NAME  = 4'd0;
  localparam logic [3:0] FLD_TIME  = 4'd1;
  localparam logic [3:0] FLD_SAT   = 4'd7;
  localparam logic [3:0] FLD_DATE  = 4'd9;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Index 0 holds the first character.
  localparam logic [NAME_LEN-1:0][7:0] NAME_RMC = {"C", "M", "R", "P", "G"};
  localparam logic [NAME_LEN-1:0][7:0] NAME_GGA = {"A", "G", "G", "P", "G"};

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RMC,
    KIND_GGA,
    KIND_OTHER
  } kind_t;

  // Kept characters of the last stored time, date and satellite fields.
  typedef struct packed {
    logic [SAT_LEN-1:0][7:0]  sat_chars;
    logic [DATE_LEN-1:0][7:0] date_chars;
    logic [TIME_LEN-1:0][7:0] time_chars;
  } keep_t;

  // One result item; fix_ready is the lowest bit.
  typedef struct packed {
    logic [6:0] satellites;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic       fix_ready;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // (a-'0')*10 + (b-'0'), wrapped to 8 bits.
  function automatic logic [7:0] two_digits(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] av;
    logic [7:0] bv;
    av = a - CH_ZERO;
    bv = b - CH_ZERO;
    return {av[4:0], 3'b000} + {av[6:0], 1'b0} + bv;
  endfunction

endpackage

/* src/nmea_field_track.sv */
// ----------------------------------------------------------------------------
// nmea_field_track
// Field buffer, counters, sentence kind and kept fields; one byte per cycle while acc is high.
// ----------------------------------------------------------------------------
module nmea_field_track (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      rx_byte,
  output nmea_pkg::keep_t keep_nxt,
  output logic            ready_nxt
);

  logic [nmea_pkg::FIELD_LEN-1:0][7:0] chars_r, chars_nxt;
  logic [nmea_pkg::CC_W-1:0]           cc_r, cc_nxt;
  logic [3:0]                          fc_r, fc_nxt;
  nmea_pkg::kind_t                     kind_r, kind_nxt;
  logic                                rmc_seen_r, rmc_seen_nxt;
  logic                                gga_seen_r, gga_seen_nxt;
  nmea_pkg::keep_t                     keep_r;
  logic                                is_rmc, is_gga;
  logic                                rmc_set, gga_set;

  always_comb begin
    is_rmc = (cc_r == nmea_pkg::CC_W'(nmea_pkg::NAME_LEN));
    is_gga = is_rmc;
    for (int i = 0; i < nmea_pkg::NAME_LEN; i++) begin
      if (chars_r[i] != nmea_pkg::NAME_RMC[i]) is_rmc = 1'b0;
      if (chars_r[i] != nmea_pkg::NAME_GGA[i]) is_gga = 1'b0;
    end
  end

  always_comb begin
    chars_nxt    = chars_r;
    cc_nxt       = cc_r;
    fc_nxt       = fc_r;
    kind_nxt     = kind_r;
    rmc_seen_nxt = rmc_seen_r;
    gga_seen_nxt = gga_seen_r;
    keep_nxt     = keep_r;
    ready_nxt    = 1'b0;
    rmc_set      = rmc_seen_r || (kind_r == nmea_pkg::KIND_RMC);
    gga_set      = gga_seen_r || (kind_r == nmea_pkg::KIND_GGA);
    unique case (rx_byte)
      nmea_pkg::CH_DOLLAR: begin
        cc_nxt = '0;
        fc_nxt = '0;
      end
      nmea_pkg::CH_COMMA: begin
        if (fc_r == nmea_pkg::FLD_NAME) begin
          if (is_rmc)      kind_nxt = nmea_pkg::KIND_RMC;
          else if (is_gga) kind_nxt = nmea_pkg::KIND_GGA;
          else             kind_nxt = nmea_pkg::KIND_OTHER;
        end else if (kind_r == nmea_pkg::KIND_RMC && fc_r == nmea_pkg::FLD_TIME) begin
          // strcpy-like: chars, one zero, older bytes past it stay
          for (int i = 0; i < nmea_pkg::TIME_LEN; i++) begin
            if (nmea_pkg::CC_W'(i) < cc_r)       keep_nxt.time_chars[i] = chars_r[i];
            else if (nmea_pkg::CC_W'(i) == cc_r) keep_nxt.time_chars[i] = 8'h00;
          end
        end else if (kind_r == nmea_pkg::KIND_RMC && fc_r == nmea_pkg::FLD_DATE) begin
          for (int i = 0; i < nmea_pkg::DATE_LEN; i++) begin
            if (nmea_pkg::CC_W'(i) < cc_r)       keep_nxt.date_chars[i] = chars_r[i];
            else if (nmea_pkg::CC_W'(i) == cc_r) keep_nxt.date_chars[i] = 8'h00;
          end
        end else if (kind_r == nmea_pkg::KIND_GGA && fc_r == nmea_pkg::FLD_SAT) begin
          for (int i = 0; i < nmea_pkg::SAT_LEN; i++) begin
            if (nmea_pkg::CC_W'(i) < cc_r)       keep_nxt.sat_chars[i] = chars_r[i];
            else if (nmea_pkg::CC_W'(i) == cc_r) keep_nxt.sat_chars[i] = 8'h00;
          end
        end
        if (fc_r != nmea_pkg::FIELD_MAX) fc_nxt = fc_r + 4'd1;
        cc_nxt = '0;
      end
      nmea_pkg::CH_CR: begin
        if (rmc_set && gga_set) begin
          rmc_seen_nxt = 1'b0;
          gga_seen_nxt = 1'b0;
          ready_nxt    = 1'b1;
        end else begin
          rmc_seen_nxt = rmc_set;
          gga_seen_nxt = gga_set;
        end
      end
      default: begin
        // drop characters past the end of the buffer
        if (cc_r < nmea_pkg::CC_W'(nmea_pkg::FIELD_LEN)) begin
          chars_nxt[cc_r[nmea_pkg::IDX_W-1:0]] = rx_byte;
          cc_nxt = cc_r + nmea_pkg::CC_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r       <= '0;
      fc_r       <= '0;
      kind_r     <= nmea_pkg::KIND_NONE;
      rmc_seen_r <= 1'b0;
      gga_seen_r <= 1'b0;
      keep_r     <= '0;
    end else if (acc) begin
      cc_r       <= cc_nxt;
      fc_r       <= fc_nxt;
      kind_r     <= kind_nxt;
      rmc_seen_r <= rmc_seen_nxt;
      gga_seen_r <= gga_seen_nxt;
      keep_r     <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      chars_r <= chars_nxt;
    end
  end

endmodule

/* src/nmea_decode.sv */
// ----------------------------------------------------------------------------
// nmea_decode
// Turn kept ASCII characters into binary time, date and satellite count.
// ----------------------------------------------------------------------------
module nmea_decode (
  input  nmea_pkg::keep_t   keep,
  input  logic              fix_ready,
  output nmea_pkg::result_t result
);

  logic [7:0] s0, s1;
  logic [6:0] sats;

  always_comb begin
    s0 = keep.sat_chars[0] - nmea_pkg::CH_ZERO;
    s1 = keep.sat_chars[1] - nmea_pkg::CH_ZERO;
    sats = '0;
    if (nmea_pkg::is_digit(keep.sat_chars[0])) begin
      sats = s0[6:0];
      if (nmea_pkg::is_digit(keep.sat_chars[1])) begin
        sats = {s0[3:0], 3'b000} + {s0[5:0], 1'b0} + s1[6:0];
      end
    end
  end

  always_comb begin
    result.fix_ready  = fix_ready;
    result.hour       = nmea_pkg::two_digits(keep.time_chars[0], keep.time_chars[1]);
    result.minute     = nmea_pkg::two_digits(keep.time_chars[2], keep.time_chars[3]);
    result.second     = nmea_pkg::two_digits(keep.time_chars[4], keep.time_chars[5]);
    result.day        = nmea_pkg::two_digits(keep.date_chars[0], keep.date_chars[1]);
    result.month      = nmea_pkg::two_digits(keep.date_chars[2], keep.date_chars[3]);
    result.year       = nmea_pkg::two_digits(keep.date_chars[4], keep.date_chars[5]);
    result.satellites = sats;
  end

endmodule

/* src/nmea_rmc_gga_field_parser.sv */
// ----------------------------------------------------------------------------
// nmea_rmc_gga_field_parser
// Byte-stream parser for GPRMC/GPGGA sentences with decoded time, date, sats.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata bits (low to high)
//  --------+-----+--------------------------------------------------------------
//  in_     | in  | rx_byte[7:0]
//  out_    | out | fix_ready[0] hour[8:1] minute[16:9] second[24:17]
//          |     | day[32:25] month[40:33] year[48:41] satellites[55:49]
//
//  One request per cycle while the output is not stalled: each accepted byte
//  updates the parser state and loads its result into the output register on
//  the same edge, so it is offered in the cycle after; one byte per clock.
//  Reset (rst_n low, synchronous) clears counters, sentence kind, seen marks,
//  kept fields and the output valid; the open field buffer is not cleared.
//  A stalled output holds its result and stops input until the cycle it is taken.
//
module nmea_rmc_gga_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // fix_ready, hour, minute, second, day, month,
                                  // year, satellites
);

  logic              acc;
  nmea_pkg::keep_t   keep_nxt;
  logic              ready_nxt;
  nmea_pkg::result_t result_nxt;
  nmea_pkg::result_t result_r;
  logic              out_valid_r;

  // Take a byte whenever the output register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  nmea_field_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_tdata),
    .keep_nxt  (keep_nxt),
    .ready_nxt (ready_nxt)
  );

  // Decode from the state the byte leaves behind.
  nmea_decode u_decode (
    .keep      (keep_nxt),
    .fix_ready (ready_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (acc) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

  // An accepted byte always produces a result next cycle.
  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted byte produced no result");

  // A held result blocks the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while result stalled");

  // Only a carriage return can raise the fix pulse.
  a_ready_from_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata != nmea_pkg::CH_CR)) |=> !out_tdata[0])
    else $error("fix_ready without carriage return");

  // Hold the result stable while stalled.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NMEA RMC/GGA field parser. A short table of
// hand-picked bytes runs first. Random sentences follow: well-formed RMC and
// GGA with random field contents, odd names, long and cut sentences, and
// noise. Every result is compared with a behavioral copy of the parser or a typed table value.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RAND_BYTES  = 1500;
  localparam int IDLE_PCT    = 36;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 300;   // random byte count where the long stall starts
  localparam int DRAIN_AT    = 700;   // random byte count where the sender waits for all results
  localparam int DRAIN_LIMIT = 1000;
  localparam int QUIET_A_LO  = 300;
  localparam int QUIET_A_HI  = 450;
  localparam int QUIET_B_LO  = 900;
  localparam int QUIET_B_HI  = 1200;

  localparam int KEEP_LEN = nmea_pkg::TIME_LEN + nmea_pkg::DATE_LEN + nmea_pkg::SAT_LEN;
  localparam int TIME_AT  = 0;
  localparam int DATE_AT  = nmea_pkg::TIME_LEN;
  localparam int SAT_AT   = nmea_pkg::TIME_LEN + nmea_pkg::DATE_LEN;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // Decode of all-zero kept fields: (0 - '0') * 10 + (0 - '0') wraps to 240.
  localparam nmea_pkg::result_t BLANK_FIX = '{satellites: 7'd0, year: 8'd240,
                                              month: 8'd240, day: 8'd240,
                                              second: 8'd240, minute: 8'd240,
                                              hour: 8'd240, fix_ready: 1'b0};

  // One row of the directed table: the byte, and the result to expect when it
  // can be written down directly (otherwise the behavioral copy decides).
  typedef struct packed {
    logic [7:0]        ch;
    logic              typed;
    nmea_pkg::result_t want;
  } step_t;

  typedef enum {
    EDIT_SWAP,
    EDIT_SHORT,
    EDIT_LONG,
    EDIT_LOWER
  } name_edit_t;

  localparam int N_DIRECTED = 26;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    // Extremes of the byte, then a carriage return before any sentence is known.
    '{8'h00, 1'b1, BLANK_FIX},
    '{8'hFF, 1'b1, BLANK_FIX},
    '{nmea_pkg::CH_CR, 1'b1, BLANK_FIX},
    // GPRMC with time 23:59:59, closed and marked seen.
    '{nmea_pkg::CH_DOLLAR, 1'b0, '0},
    '{"G", 1'b0, '0}, '{"P", 1'b0, '0}, '{"R", 1'b0, '0}, '{"M", 1'b0, '0},
    '{"C", 1'b0, '0},
    '{nmea_pkg::CH_COMMA, 1'b0, '0},
    '{"2", 1'b0, '0}, '{"3", 1'b0, '0}, '{"5", 1'b0, '0}, '{"9", 1'b0, '0},
    '{"5", 1'b0, '0}, '{"9", 1'b0, '0},
    '{nmea_pkg::CH_COMMA, 1'b0, '0},
    '{nmea_pkg::CH_CR, 1'b0, '0},
    // GPGGA name only, then the carriage return that completes the fix.
    '{nmea_pkg::CH_DOLLAR, 1'b0, '0},
    '{"G", 1'b0, '0}, '{"P", 1'b0, '0}, '{"G", 1'b0, '0}, '{"G", 1'b0, '0},
    '{"A", 1'b0, '0},
    '{nmea_pkg::CH_COMMA, 1'b0, '0},
    '{nmea_pkg::CH_CR, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // rx_byte[7:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;            // fix_ready, hour, minute, second, day,
                                     // month, year, satellites

  always #1 clk = ~clk;

  nmea_rmc_gga_field_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Behavioral copy of the parser
  // --------------------------------------------------------------------------
  logic [7:0]      open_chars [nmea_pkg::FIELD_LEN];
  int unsigned     open_len;
  logic [3:0]      field_idx;
  nmea_pkg::kind_t kind;
  bit              rmc_done;
  bit              gga_done;
  logic [7:0]      kept [KEEP_LEN];     // time, then date, then satellite characters

  nmea_pkg::result_t decodes_due [$];   // one decoded result per accepted byte

  function automatic bit is_num(input logic [7:0] ch);
    return (ch >= nmea_pkg::CH_ZERO) && (ch <= nmea_pkg::CH_NINE);
  endfunction

  // Two ASCII digits to a value, wrapping in 8 bits like the hardware.
  function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] tens;
    logic [7:0] ones;
    tens = hi - nmea_pkg::CH_ZERO;
    ones = lo - nmea_pkg::CH_ZERO;
    return 8'(tens * 8'd10 + ones);
  endfunction

  function automatic bit name_match(input logic [nmea_pkg::NAME_LEN-1:0][7:0] name);
    if (open_len != nmea_pkg::NAME_LEN) return 1'b0;
    for (int i = 0; i < nmea_pkg::NAME_LEN; i++) begin
      if (open_chars[i] != name[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Copy the open field string-style: characters, then one zero if it fits;
  // leave whatever lies past that zero.
  function automatic void keep_field(input int base, input int len);
    for (int i = 0; i < len; i++) begin
      if (i < open_len) begin
        kept[base + i] = open_chars[i];
      end else begin
        kept[base + i] = 8'h00;
        break;
      end
    end
  endfunction

  function automatic nmea_pkg::result_t parse_char(input logic [7:0] ch);
    nmea_pkg::result_t r;
    logic              ready;
    logic [6:0]        sats;
    ready = 1'b0;
    if (ch == nmea_pkg::CH_DOLLAR) begin
      open_len  = 0;
      field_idx = nmea_pkg::FLD_NAME;
    end else if (ch == nmea_pkg::CH_COMMA) begin
      if (field_idx == nmea_pkg::FLD_NAME) begin
        if (name_match(nmea_pkg::NAME_RMC))      kind = nmea_pkg::KIND_RMC;
        else if (name_match(nmea_pkg::NAME_GGA)) kind = nmea_pkg::KIND_GGA;
        else                                     kind = nmea_pkg::KIND_OTHER;
      end else if (kind == nmea_pkg::KIND_RMC && field_idx == nmea_pkg::FLD_TIME) begin
        keep_field(TIME_AT, nmea_pkg::TIME_LEN);
      end else if (kind == nmea_pkg::KIND_RMC && field_idx == nmea_pkg::FLD_DATE) begin
        keep_field(DATE_AT, nmea_pkg::DATE_LEN);
      end else if (kind == nmea_pkg::KIND_GGA && field_idx == nmea_pkg::FLD_SAT) begin
        keep_field(SAT_AT, nmea_pkg::SAT_LEN);
      end
      if (field_idx != nmea_pkg::FIELD_MAX) field_idx++;
      open_len = 0;
    end else if (ch == nmea_pkg::CH_CR) begin
      // Mark the current kind; counters stay as they are.
      if (kind == nmea_pkg::KIND_RMC) rmc_done = 1'b1;
      if (kind == nmea_pkg::KIND_GGA) gga_done = 1'b1;
      if (rmc_done && gga_done) begin
        rmc_done = 1'b0;
        gga_done = 1'b0;
        ready    = 1'b1;
      end
    end else if (open_len < nmea_pkg::FIELD_LEN) begin
      // Drop characters past the end of the field buffer.
      open_chars[open_len] = ch;
      open_len++;
    end

    sats = '0;
    if (is_num(kept[SAT_AT])) begin
      sats = 7'(kept[SAT_AT] - nmea_pkg::CH_ZERO);
      if (is_num(kept[SAT_AT + 1])) begin
        sats = 7'(sats * 10 + (kept[SAT_AT + 1] - nmea_pkg::CH_ZERO));
      end
    end

    r.fix_ready  = ready;
    r.hour       = decode_pair(kept[TIME_AT],     kept[TIME_AT + 1]);
    r.minute     = decode_pair(kept[TIME_AT + 2], kept[TIME_AT + 3]);
    r.second     = decode_pair(kept[TIME_AT + 4], kept[TIME_AT + 5]);
    r.day        = decode_pair(kept[DATE_AT],     kept[DATE_AT + 1]);
    r.month      = decode_pair(kept[DATE_AT + 2], kept[DATE_AT + 3]);
    r.year       = decode_pair(kept[DATE_AT + 4], kept[DATE_AT + 5]);
    r.satellites = sats;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sentence builder
  // --------------------------------------------------------------------------
  logic [7:0]  line_q [$];

  // Usually the given length; otherwise anything from empty to overlong.
  function automatic int pick_len(input int usual);
    return ($urandom_range(99) < 70) ? usual : int'($urandom_range(nmea_pkg::FIELD_LEN + 4));
  endfunction

  // Append len characters, mostly digits; keep separators out of the text.
  task automatic add_text(input int len, input int digit_pct);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < digit_pct) ch = nmea_pkg::CH_ZERO + 8'($urandom_range(9));
      else                                ch = 8'($urandom_range(255));
      if (ch == nmea_pkg::CH_DOLLAR || ch == nmea_pkg::CH_COMMA || ch == nmea_pkg::CH_CR) begin
        ch = "A";
      end
      line_q.push_back(ch);
    end
  endtask

  task automatic add_name(input logic [nmea_pkg::NAME_LEN-1:0][7:0] name);
    line_q.push_back(nmea_pkg::CH_DOLLAR);
    for (int i = 0; i < nmea_pkg::NAME_LEN; i++) line_q.push_back(name[i]);
  endtask

  // Append n fields, each opened by a comma, so field n itself stays open.
  // Time, date and satellite positions get field-like contents.
  task automatic add_fields(input int n, input bit close);
    for (int f = 1; f <= n; f++) begin
      line_q.push_back(nmea_pkg::CH_COMMA);
      if (f == nmea_pkg::FLD_TIME)      add_text(pick_len(nmea_pkg::TIME_LEN), 90);
      else if (f == nmea_pkg::FLD_DATE) add_text(pick_len(nmea_pkg::DATE_LEN), 90);
      else if (f == nmea_pkg::FLD_SAT)  add_text(pick_len(nmea_pkg::SAT_LEN), 90);
      else                              add_text(pick_len($urandom_range(5)), 50);
    end
    if (close) begin
      line_q.push_back(CH_STAR);
      add_text(2, 50);
      line_q.push_back(nmea_pkg::CH_CR);
      line_q.push_back(CH_LF);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  bit          quiet;          // no random idling on either side while set
  int          hold_reqs;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned fix_pulses;
  int unsigned errors;

  // Offer one byte, idling at random first; on acceptance advance the
  // behavioral copy and queue the result to expect.
  task automatic push_byte(input logic [7:0] ch, input bit typed,
                           input nmea_pkg::result_t want);
    nmea_pkg::result_t model;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    model = parse_char(ch);
    decodes_due.push_back(typed ? want : model);
    bytes_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here
  // --------------------------------------------------------------------------
  int hold_seen;
  int hold_left;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic check_field(input string label, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", label, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    nmea_pkg::result_t got;
    nmea_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = nmea_pkg::result_t'(out_tdata);
      if (decodes_due.size() == 0) begin
        $error("result %h with no request outstanding", out_tdata);
        errors++;
      end else begin
        want = decodes_due.pop_front();
        results_seen++;
        if (got.fix_ready === 1'b1) fix_pulses++;
        check_field("fix_ready",  8'(want.fix_ready),  8'(got.fix_ready));
        check_field("hour",       want.hour,           got.hour);
        check_field("minute",     want.minute,         got.minute);
        check_field("second",     want.second,         got.second);
        check_field("day",        want.day,            got.day);
        check_field("month",      want.month,          got.month);
        check_field("year",       want.year,           got.year);
        check_field("satellites", 8'(want.satellites), 8'(got.satellites));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rand_sent;
    int unsigned wait_cycles;
    int unsigned n_rmc, n_gga, n_odd, n_long, n_cut, n_noise;
    int          pick;
    bit          held;
    bit          drained;
    name_edit_t  edit;
    int          pos;
    logic [7:0]  ch;
    logic [nmea_pkg::NAME_LEN-1:0][7:0] name;

    rand_sent = 0;
    n_rmc = 0; n_gga = 0; n_odd = 0; n_long = 0; n_cut = 0; n_noise = 0;
    held = 1'b0;
    drained = 1'b0;

    // Start the behavioral copy from the reset state; the open field buffer
    // is never read past its fill count, so its contents do not matter.
    foreach (open_chars[i]) open_chars[i] = 8'h00;
    foreach (kept[i]) kept[i] = 8'h00;
    open_len  = 0;
    field_idx = nmea_pkg::FLD_NAME;
    kind      = nmea_pkg::KIND_NONE;
    rmc_done  = 1'b0;
    gga_done  = 1'b0;

    // Hold reset, then release it once for the whole run.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (DIRECTED[i]) push_byte(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].want);

    // Random sentences until enough bytes went in.
    while (rand_sent < RAND_BYTES) begin
      quiet = (rand_sent >= QUIET_A_LO && rand_sent < QUIET_A_HI) ||
              (rand_sent >= QUIET_B_LO && rand_sent < QUIET_B_HI);

      // Stall the receiver for a long stretch while bytes keep coming.
      if (!held && rand_sent >= HOLD_AT) begin
        held = 1'b1;
        hold_reqs++;
      end

      // Pause the sender until every outstanding result has come back.
      if (!drained && rand_sent >= DRAIN_AT) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (decodes_due.size() != 0);
      end

      pick = $urandom_range(99);
      if (pick < 35) begin
        n_rmc++;
        add_name(nmea_pkg::NAME_RMC);
        add_fields($urandom_range(13, 10), 1'b1);
      end else if (pick < 70) begin
        n_gga++;
        add_name(nmea_pkg::NAME_GGA);
        add_fields($urandom_range(14, 8), 1'b1);
      end else if (pick < 80) begin
        // Near-miss names: mostly nothing in these is kept.
        n_odd++;
        name = $urandom_range(1) ? nmea_pkg::NAME_RMC : nmea_pkg::NAME_GGA;
        edit = name_edit_t'($urandom_range(EDIT_LOWER));
        pos  = $urandom_range(nmea_pkg::NAME_LEN - 1);
        line_q.push_back(nmea_pkg::CH_DOLLAR);
        for (int i = 0; i < nmea_pkg::NAME_LEN; i++) begin
          ch = name[i];
          if (edit == EDIT_SWAP && i == pos) ch = "A" + 8'($urandom_range(25));
          if (edit == EDIT_LOWER) ch = ch | 8'h20;
          if (!(edit == EDIT_SHORT && i == nmea_pkg::NAME_LEN - 1)) line_q.push_back(ch);
        end
        if (edit == EDIT_LONG) line_q.push_back("A" + 8'($urandom_range(25)));
        add_fields($urandom_range(12, 1), 1'b1);
      end else if (pick < 87) begin
        // Run the field index into saturation.
        n_long++;
        add_name($urandom_range(1) ? nmea_pkg::NAME_RMC : nmea_pkg::NAME_GGA);
        add_fields($urandom_range(22, 16), 1'b1);
      end else if (pick < 93) begin
        // Cut short, sometimes with a carriage return in mid-sentence.
        n_cut++;
        add_name($urandom_range(1) ? nmea_pkg::NAME_RMC : nmea_pkg::NAME_GGA);
        add_fields($urandom_range(11), 1'b0);
        if ($urandom_range(1)) begin
          line_q.push_back(nmea_pkg::CH_CR);
          add_fields($urandom_range(3), 1'b0);
        end
      end else begin
        n_noise++;
        repeat ($urandom_range(12, 1)) line_q.push_back(8'($urandom_range(255)));
      end

      foreach (line_q[i]) push_byte(line_q[i], 1'b0, BLANK_FIX);
      rand_sent += line_q.size();
      line_q.delete();
    end
    quiet = 1'b0;

    // Drain: wait for the outstanding results before the final check.
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (decodes_due.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (decodes_due.size() != 0) begin
      $error("%0d results never arrived", decodes_due.size());
      errors++;
    end

    $display("Sent %0d bytes: %0d RMC, %0d GGA, %0d odd-name, %0d long, %0d cut, %0d noise",
             bytes_sent, n_rmc, n_gga, n_odd, n_long, n_cut, n_noise);
    $display("Checked %0d results, %0d fix pulses, %0d mismatches",
             results_seen, fix_pulses, errors);
    if (errors == 0) begin
      $display("nmea_rmc_gga_field_parser test passed");
    end else begin
      $display("nmea_rmc_gga_field_parser test failed");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    #1_000_000;
    $display("nmea_rmc_gga_field_parser test failed");
    $finish;
  end

endmodule

/* nmea_rmc_gga_field_parser.f */
src/nmea_pkg.sv
src/nmea_field_track.sv
src/nmea_decode.sv
src/nmea_rmc_gga_field_parser.sv
sim/tb_top.sv
